FILE: rtl/integer_to_ascii_formatter_top_defines.svh
// Assertion macros used by the formatter's top-level file.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ITA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ITA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ita_pkg.sv
// Types, constants and helpers shared by the integer-to-ASCII formatter.
`timescale 1ns / 1ps

package ita_pkg;

    // Pad counts are carried at the width that covers the largest MAX_PAD (63)
    localparam int PAD_W   = 6;
    localparam int VAL_W   = 32;
    localparam int DIGITS  = 10;
    localparam int HEX_DIG = VAL_W / 4;
    localparam int LEN_W   = 4;
    localparam int CONV_W  = 5;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Classified request handed from front to back
    typedef struct packed {
        logic [VAL_W-1:0] mag;
        logic             hex;
        logic             up;
        logic             zf;
        logic             neg;
        logic             pg;
        logic [PAD_W-1:0] prec;
        logic             pad_on;
        logic [PAD_W-1:0] top;
    } t_desc;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_LEN,
        S_PAD,
        S_SIGN,
        S_DIG
    } t_state;

    // One digit value to its ASCII code
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] base;
        base = up ? CH_UP_A : CH_LOW_A;
        if (d < 4'd10) begin
            return CH_ZERO + {4'b0, d};
        end else begin
            return base + {4'b0, d} - 8'd10;
        end
    endfunction

endpackage

FILE: rtl/ita_front.sv
// Front end: accepts requests, saturates pads, takes the sign and magnitude.
`timescale 1ns / 1ps

module ita_front import ita_pkg::*; #(
    parameter int MAX_PAD = 31
) (
    input  logic             i_push,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_is_hex,
    input  logic             i_is_signed,
    input  logic             i_upper_case,
    input  logic             i_zero_fill,
    input  logic             i_width_given,
    input  logic [4:0]       i_field_width,
    input  logic             i_prec_given,
    input  logic [4:0]       i_digit_precision,
    input  t_q_stat          i_q_stat,
    output logic             o_push,
    output t_desc            o_desc
);

    localparam logic [PAD_W-1:0] PAD_LIM = PAD_W'(MAX_PAD);

    logic [PAD_W-1:0] w_wid;
    logic [PAD_W-1:0] w_prec;
    logic [PAD_W-1:0] w_wsat;
    logic [PAD_W-1:0] w_psat;
    logic             w_neg;

    // Saturate width and precision; a field not given counts as zero here
    assign w_wid  = PAD_W'(i_field_width);
    assign w_prec = PAD_W'(i_digit_precision);
    assign w_wsat = !i_width_given ? '0 : ((w_wid > PAD_LIM) ? PAD_LIM : w_wid);
    assign w_psat = !i_prec_given  ? '0 : ((w_prec > PAD_LIM) ? PAD_LIM : w_prec);

    // Minus only for signed decimal
    assign w_neg = !i_is_hex && i_is_signed && i_value[VAL_W-1];

    always_comb begin
        o_desc.mag    = w_neg ? (VAL_W'(0) - i_value) : i_value;
        o_desc.hex    = i_is_hex;
        o_desc.up     = i_upper_case;
        o_desc.zf     = i_zero_fill;
        o_desc.neg    = w_neg;
        o_desc.pg     = i_prec_given;
        o_desc.prec   = w_psat;
        o_desc.pad_on = i_width_given || i_prec_given;
        o_desc.top    = (w_psat > w_wsat) ? w_psat : w_wsat;
    end

    assign o_push = i_push && !i_q_stat.full;

endmodule

FILE: rtl/ita_queue.sv
// Two-entry request queue between front and back.
`timescale 1ns / 1ps

module ita_queue import ita_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_desc   i_data,
    input  logic    i_pop,
    output t_desc   o_data,
    output t_q_stat o_stat
);

    t_desc              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/ita_back.sv
// Back end: digit conversion, padding layout and character output register.
`timescale 1ns / 1ps

module ita_back import ita_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_desc      i_desc,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    t_state             r_state, n_state;
    logic [VAL_W-1:0]   r_bin, n_bin;
    logic [3:0]         r_dig [DIGITS];
    logic [3:0]         n_dig [DIGITS];
    logic [CONV_W-1:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [PAD_W-1:0]   r_i, n_i;
    logic [LEN_W-1:0]   r_d, n_d;
    logic               r_neg, n_neg;
    logic               r_up, n_up;
    logic               r_zf, n_zf;
    logic               r_pg, n_pg;
    logic [PAD_W-1:0]   r_prec, n_prec;
    logic               r_pad_on, n_pad_on;
    logic [PAD_W-1:0]   r_top, n_top;
    logic               r_ov, n_ov;
    logic [7:0]         r_char, n_char;
    logic               r_last, n_last;

    logic [3:0]         w_adj [DIGITS];
    logic [LEN_W-1:0]   w_len;
    logic               w_emit_ok;
    logic [PAD_W:0]     w_len_p1;
    logic [PAD_W:0]     w_prec_p1;
    logic               w_in_prec;
    logic [7:0]         w_pad_char;

    assign w_emit_ok = !r_ov || i_pop;

    // Double-dabble adjust: digits of five or more get three added
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            w_adj[k] = (r_dig[k] >= 4'd5) ? (r_dig[k] + 4'd3) : r_dig[k];
        end
    end

    // Digit count from the highest nonzero digit, at least one
    always_comb begin
        w_len = LEN_W'(1);
        for (int k = 0; k < DIGITS; k++) begin
            if (r_dig[k] != 4'd0) begin
                w_len = LEN_W'(k + 1);
            end
        end
    end

    // Pad character at position r_i
    assign w_len_p1  = (PAD_W+1)'(r_len) + 1'b1;
    assign w_prec_p1 = (PAD_W+1)'(r_prec) + 1'b1;
    assign w_in_prec = r_pg && (r_i <= r_prec);

    always_comb begin
        if (w_in_prec || r_zf) begin
            w_pad_char = r_neg ? CH_MINUS : CH_ZERO;
        end else if (r_neg && ((!r_pg && ((PAD_W+1)'(r_i) <= w_len_p1)) ||
                               (r_pg && ((PAD_W+1)'(r_i) <= w_prec_p1)))) begin
            w_pad_char = CH_MINUS;
        end else begin
            w_pad_char = CH_SPACE;
        end
    end

    // Next state and outputs
    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_dig    = r_dig;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_i      = r_i;
        n_d      = r_d;
        n_neg    = r_neg;
        n_up     = r_up;
        n_zf     = r_zf;
        n_pg     = r_pg;
        n_prec   = r_prec;
        n_pad_on = r_pad_on;
        n_top    = r_top;
        n_ov     = i_pop ? 1'b0 : r_ov;
        n_char   = r_char;
        n_last   = r_last;
        o_q_pop  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_pop  = 1'b1;
                    n_neg    = i_desc.neg;
                    n_up     = i_desc.up;
                    n_zf     = i_desc.zf;
                    n_pg     = i_desc.pg;
                    n_prec   = i_desc.prec;
                    n_pad_on = i_desc.pad_on;
                    n_top    = i_desc.top;
                    n_bin    = i_desc.mag;
                    n_cnt    = '0;
                    if (i_desc.hex) begin
                        for (int k = 0; k < DIGITS; k++) begin
                            n_dig[k] = (k < HEX_DIG) ? i_desc.mag[4*(k % HEX_DIG) +: 4]
                                                     : 4'd0;
                        end
                        n_state = S_LEN;
                    end else begin
                        for (int k = 0; k < DIGITS; k++) begin
                            n_dig[k] = 4'd0;
                        end
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                // One binary bit shifted into the BCD digits per cycle
                n_dig[0] = {w_adj[0][2:0], r_bin[VAL_W-1]};
                for (int k = 1; k < DIGITS; k++) begin
                    n_dig[k] = {w_adj[k][2:0], w_adj[k-1][3]};
                end
                n_bin = {r_bin[VAL_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CONV_W'(VAL_W - 1)) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_len = w_len;
                n_d   = w_len - 1'b1;
                n_i   = r_top;
                if (r_pad_on && (r_top > PAD_W'(w_len))) begin
                    n_state = S_PAD;
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIG;
                end
            end
            S_PAD: begin
                if (w_emit_ok) begin
                    n_ov   = 1'b1;
                    n_char = w_pad_char;
                    n_last = 1'b0;
                    n_neg  = r_neg && (w_pad_char != CH_MINUS);
                    n_i    = r_i - 1'b1;
                    if ((PAD_W+1)'(r_i) == w_len_p1) begin
                        n_state = n_neg ? S_SIGN : S_DIG;
                    end
                end
            end
            S_SIGN: begin
                if (w_emit_ok) begin
                    n_ov    = 1'b1;
                    n_char  = CH_MINUS;
                    n_last  = 1'b0;
                    n_neg   = 1'b0;
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (w_emit_ok) begin
                    n_ov   = 1'b1;
                    n_char = digit_char(r_dig[r_d], r_up);
                    n_last = (r_d == '0);
                    n_d    = r_d - 1'b1;
                    if (r_d == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Working and output data registers
    always_ff @(posedge i_clk) begin
        r_bin    <= n_bin;
        r_dig    <= n_dig;
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_i      <= n_i;
        r_d      <= n_d;
        r_neg    <= n_neg;
        r_up     <= n_up;
        r_zf     <= n_zf;
        r_pg     <= n_pg;
        r_prec   <= n_prec;
        r_pad_on <= n_pad_on;
        r_top    <= n_top;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_empty    = !r_ov;
    assign o_out_char = r_char;
    assign o_last     = r_last;

endmodule

FILE: rtl/integer_to_ascii_formatter_top.sv
// Flow: a request accepted on push is visible to the back end in the next cycle; hex
// goes straight to the length step, decimal first runs the double-dabble conversion.
// Output: one char per cycle while pop takes each char, and the 2-entry request
// queue accepts new requests while the back end works.
// Reset: synchronous, active low; empties queue and output, back end returns to idle.
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_top_defines.svh"

module integer_to_ascii_formatter_top import ita_pkg::*; #(
    parameter int MAX_PAD = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_is_hex,
    input  logic             i_is_signed,
    input  logic             i_upper_case,
    input  logic             i_zero_fill,
    input  logic             i_width_given,
    input  logic [4:0]       i_field_width,
    input  logic             i_prec_given,
    input  logic [4:0]       i_digit_precision,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       o_out_char,
    output logic             o_last
);

    t_q_stat w_q_stat;
    t_desc   w_front_desc;
    t_desc   w_back_desc;
    logic    w_q_push;
    logic    w_q_pop;

    // Request classification
    ita_front #(
        .MAX_PAD (MAX_PAD)
    ) u_front (
        .i_push            (push),
        .i_value           (i_value),
        .i_is_hex          (i_is_hex),
        .i_is_signed       (i_is_signed),
        .i_upper_case      (i_upper_case),
        .i_zero_fill       (i_zero_fill),
        .i_width_given     (i_width_given),
        .i_field_width     (i_field_width),
        .i_prec_given      (i_prec_given),
        .i_digit_precision (i_digit_precision),
        .i_q_stat          (w_q_stat),
        .o_push            (w_q_push),
        .o_desc            (w_front_desc)
    );

    // Decoupling queue
    ita_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_desc),
        .i_pop   (w_q_pop),
        .o_data  (w_back_desc),
        .o_stat  (w_q_stat)
    );

    // Conversion and character output
    ita_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_desc     (w_back_desc),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

    assign full = w_q_stat.full;

    // An accepted request is visible to the back end on the next cycle
    `ITA_ASSERT_NXT(a_push_lands, push && !full, !w_q_stat.empty, "accepted request lost")

    // The final char of a request is always a digit
    `ITA_ASSERT_IMP(a_last_is_digit, !empty && o_last,
        ((o_out_char >= CH_ZERO) && (o_out_char <= CH_ZERO + 8'd9)) ||
        ((o_out_char >= CH_LOW_A) && (o_out_char <= CH_LOW_A + 8'd5)) ||
        ((o_out_char >= CH_UP_A) && (o_out_char <= CH_UP_A + 8'd5)),
        "last char is not a digit")

    // Inside a request, popping a char never leaves a gap before the next one
    `ITA_ASSERT_NXT(a_no_gap, pop && !empty && !o_last, !empty, "gap inside request text")

endmodule

FILE: dv/tb_integer_to_ascii_formatter_top.sv
// Testbench for the integer-to-ASCII formatter: directed and random requests checked per char.
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter_top;
    import ita_pkg::*;

    localparam int PAD_LIMIT    = 31;
    localparam int RANDOM_REQS  = 387;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;

    // One formatting request as seen on the push side
    typedef struct {
        logic [31:0] value;
        logic        is_hex;
        logic        is_signed;
        logic        upper_case;
        logic        zero_fill;
        logic        width_given;
        logic [4:0]  field_width;
        logic        prec_given;
        logic [4:0]  digit_precision;
    } t_fmt_req;

    // One expected output character
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_fmt_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_value = '0;
    logic        i_is_hex = 1'b0;
    logic        i_is_signed = 1'b0;
    logic        i_upper_case = 1'b0;
    logic        i_zero_fill = 1'b0;
    logic        i_width_given = 1'b0;
    logic [4:0]  i_field_width = '0;
    logic        i_prec_given = 1'b0;
    logic [4:0]  i_digit_precision = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_last;

    t_fmt_char   pending_chars [$];
    int          mismatches = 0;
    int          reqs_sent = 0;
    int          chars_checked = 0;
    int          neg_dec_reqs = 0;
    int          hex_reqs = 0;
    int          cycle_count = 0;
    int          pop_hold = 0;
    bit          no_idle = 1'b0;

    integer_to_ascii_formatter_top #(
        .MAX_PAD(PAD_LIMIT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_value          (i_value),
        .i_is_hex         (i_is_hex),
        .i_is_signed      (i_is_signed),
        .i_upper_case     (i_upper_case),
        .i_zero_fill      (i_zero_fill),
        .i_width_given    (i_width_given),
        .i_field_width    (i_field_width),
        .i_prec_given     (i_prec_given),
        .i_digit_precision(i_digit_precision),
        .empty            (empty),
        .pop              (pop),
        .o_out_char       (o_out_char),
        .o_last           (o_last)
    );

    // 100 MHz clock
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d chars still expected",
                 cycle_count, pending_chars.size());
        $display("[integer_to_ascii_formatter_top] ERROR");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic t_fmt_req mk_req(logic [31:0] v, logic hx, logic sg, logic up,
                                        logic zf, logic wg, logic [4:0] fw,
                                        logic pg, logic [4:0] dp);
        t_fmt_req r;
        r.value = v;
        r.is_hex = hx;
        r.is_signed = sg;
        r.upper_case = up;
        r.zero_fill = zf;
        r.width_given = wg;
        r.field_width = fw;
        r.prec_given = pg;
        r.digit_precision = dp;
        return r;
    endfunction

    // Predict the text of one request and queue its chars
    function automatic void format_int(t_fmt_req r);
        logic [31:0] mag;
        logic [31:0] div;
        logic [31:0] d;
        logic [7:0]  digs [12];
        logic [7:0]  txt [$];
        logic [7:0]  c;
        logic        neg;
        logic        seen;
        int          len;
        int          w;
        int          p;
        int          top;
        int          i;
        t_fmt_char   fc;
        mag  = r.value;
        neg  = 1'b0;
        seen = 1'b0;
        len  = 0;
        w = !r.width_given ? -1 :
            (int'(r.field_width) > PAD_LIMIT ? PAD_LIMIT : int'(r.field_width));
        p = !r.prec_given ? -1 :
            (int'(r.digit_precision) > PAD_LIMIT ? PAD_LIMIT : int'(r.digit_precision));

        if (r.is_hex) begin
            // nibbles from the top, leading zeros dropped, last nibble always kept
            for (int sh = 28; sh >= 0; sh -= 4) begin
                d = (mag >> sh) & 32'hF;
                if (d != 0) seen = 1'b1;
                if (seen || sh == 0) begin
                    if (d < 10)
                        digs[len] = CH_ZERO + d[7:0];
                    else
                        digs[len] = (r.upper_case ? CH_UP_A : CH_LOW_A) + d[7:0] - 8'd10;
                    len++;
                end
            end
        end else begin
            if (r.is_signed && mag[31]) begin
                neg = 1'b1;
                mag = 32'd0 - mag;
            end
            div = 32'd1000000000;
            while (div != 0) begin
                d   = mag / div;
                mag = mag % div;
                div = div / 10;
                if (d != 0 || div == 0) seen = 1'b1;
                if (seen) begin
                    digs[len] = CH_ZERO + d[7:0];
                    len++;
                end
            end
        end

        // pad from the widest slot down; the minus sign eats one pad slot
        if (p != -1 || w != -1) begin
            top = (p > w) ? p : w;
            for (i = top; i > len; i--) begin
                if (p != -1 && i <= p)
                    c = neg ? CH_MINUS : CH_ZERO;
                else if (r.zero_fill)
                    c = neg ? CH_MINUS : CH_ZERO;
                else if (neg && ((p == -1 && i - 1 <= len) || (p != -1 && i - 1 <= p)))
                    c = CH_MINUS;
                else
                    c = CH_SPACE;
                if (c == CH_MINUS) neg = 1'b0;
                txt.push_back(c);
            end
        end
        if (neg) txt.push_back(CH_MINUS);
        for (i = 0; i < len; i++) txt.push_back(digs[i]);

        foreach (txt[k]) begin
            fc.ch   = txt[k];
            fc.last = (k == txt.size() - 1);
            pending_chars.push_back(fc);
        end
    endfunction

    // Push one request, wait for it to be taken, then predict its text
    task automatic send_request(t_fmt_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push              <= 1'b1;
        i_value           <= r.value;
        i_is_hex          <= r.is_hex;
        i_is_signed       <= r.is_signed;
        i_upper_case      <= r.upper_case;
        i_zero_fill       <= r.zero_fill;
        i_width_given     <= r.width_given;
        i_field_width     <= r.field_width;
        i_prec_given      <= r.prec_given;
        i_digit_precision <= r.digit_precision;
        do @(posedge i_clk); while (full);
        format_int(r);
        reqs_sent++;
        if (r.is_hex) hex_reqs++;
        else if (r.is_signed && r.value[31]) neg_dec_reqs++;
    endtask

    function automatic void report_bad(string what, t_fmt_char want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                     $realtime, what, want.ch, want.last, o_out_char, o_last);
    endfunction

    // Result side: check every popped char and drive pop with random stalls
    always @(posedge i_clk) begin : char_check
        t_fmt_char want;
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end else begin
            if (pop && !empty) begin
                if (pending_chars.size() == 0) begin
                    want.ch   = 8'h00;
                    want.last = 1'b0;
                    report_bad("char with nothing expected", want);
                end else begin
                    want = pending_chars.pop_front();
                    if (o_out_char !== want.ch || o_last !== want.last)
                        report_bad("char mismatch", want);
                end
                chars_checked++;
            end
            if (pop_hold > 0) begin
                pop      <= 1'b0;
                pop_hold <= pop_hold - 1;
            end else begin
                pop_hold <= pick_gap();
                pop      <= 1'b1;
            end
        end
    end

    // Hex: zero, all ones in both cases, top nibble only, sign flag ignored, padding
    task automatic test_hex_cases();
        send_request(mk_req(32'h0, 1, 0, 0, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'hFFFFFFFF, 1, 0, 0, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'hFFFFFFFF, 1, 1, 1, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'hF0000000, 1, 0, 1, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'h8000ABCD, 1, 1, 0, 1, 1, 5'd31, 0, 5'd0));
        send_request(mk_req(32'h0000ABCD, 1, 0, 1, 0, 1, 5'd12, 1, 5'd31));
    endtask

    // Decimal extremes, signed and unsigned
    task automatic test_decimal_extremes();
        send_request(mk_req(32'd0, 0, 1, 0, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'hFFFFFFFF, 0, 0, 0, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'h80000000, 0, 1, 0, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'hFFFFFFFF, 0, 1, 0, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'h7FFFFFFF, 0, 1, 0, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'd1000000000, 0, 0, 0, 0, 0, 5'd0, 0, 5'd0));
        send_request(mk_req(32'h80000000, 0, 1, 0, 1, 1, 5'd31, 1, 5'd31));
    endtask

    // Sign placement, ignored flags, zero precision
    task automatic test_padding_sign();
        send_request(mk_req(-32'sd42, 0, 1, 0, 0, 1, 5'd8, 0, 5'd0));
        send_request(mk_req(-32'sd42, 0, 1, 0, 0, 1, 5'd10, 1, 5'd5));
        send_request(mk_req(-32'sd42, 0, 1, 0, 1, 1, 5'd8, 0, 5'd0));
        send_request(mk_req(-32'sd42, 0, 1, 0, 0, 0, 5'd0, 1, 5'd6));
        send_request(mk_req(-32'sd7, 0, 1, 0, 0, 1, 5'd3, 1, 5'd8));
        send_request(mk_req(32'd123, 0, 0, 0, 1, 0, 5'd31, 0, 5'd31));
        send_request(mk_req(32'd0, 0, 0, 0, 0, 0, 5'd0, 1, 5'd0));
        send_request(mk_req(32'd5, 0, 0, 0, 1, 1, 5'd0, 0, 5'd0));
        send_request(mk_req(-32'sd1, 0, 1, 0, 0, 1, 5'd2, 0, 5'd0));
    endtask

    // Random requests; value classes aim at digit-count and sign boundaries
    task automatic test_random_requests();
        t_fmt_req    r;
        logic [31:0] p10;
        for (int k = 0; k < RANDOM_REQS; k++) begin
            no_idle = ((k / 40) % 4 == 1);
            case ($urandom_range(0, 5))
                0: r.value = $urandom_range(0, 20);
                1: r.value = $urandom;
                2: r.value = 32'hFFFFFFFF - $urandom_range(0, 20);
                3: r.value = $urandom_range(0, 1) ? 32'h80000000 + $urandom_range(0, 3)
                                                  : 32'h7FFFFFFF - $urandom_range(0, 3);
                4: r.value = $urandom >> $urandom_range(0, 31);
                default: begin
                    p10 = 32'd1;
                    repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                    r.value = p10 + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1)) r.value = 32'd0 - r.value;
                end
            endcase
            r.is_hex          = ($urandom_range(0, 2) == 0);
            r.is_signed       = $urandom_range(0, 1);
            r.upper_case      = $urandom_range(0, 1);
            r.zero_fill       = $urandom_range(0, 1);
            r.width_given     = $urandom_range(0, 1);
            r.prec_given      = $urandom_range(0, 1);
            r.field_width     = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 14);
            r.digit_precision = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 14);
            send_request(r);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_hex_cases();
        test_decimal_extremes();
        test_padding_sign();
        test_random_requests();

        push <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests (%0d hex, %0d negative decimal), %0d chars checked",
                 reqs_sent, hex_reqs, neg_dec_reqs, chars_checked);
        $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("[integer_to_ascii_formatter_top] OK");
        end else begin
            $display("[integer_to_ascii_formatter_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ita_pkg.sv
rtl/ita_front.sv
rtl/ita_queue.sv
rtl/ita_back.sv
rtl/integer_to_ascii_formatter_top.sv
dv/tb_integer_to_ascii_formatter_top.sv
